/* src/tbrl_pkg.sv */
// Shared types and constants of the token bucket rate limiter.
// Depends on nothing; imported by tbrl_core and token_bucket_rate_limiter.
package tbrl_pkg;

    localparam int MODE_W   = 3;
    localparam int SPEED_W  = 16;
    localparam int STATUS_W = 2;
    localparam int AVAIL_W  = 17;
    localparam logic [AVAIL_W-1:0] AVAIL_MAX = 17'h1FFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_REQUEST = 3'd1,
        MODE_SPEED   = 3'd2,
        MODE_START   = 3'd3,
        MODE_STOP    = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_RETRY  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RS_STOPPED = 2'd0,
        RS_RUNNING = 2'd1,
        RS_PENDING = 2'd2
    } run_state_t;

endpackage

/* src/token_bucket_rate_limiter.sv */
// Top level of the token bucket rate limiter: input register, state, result register.
// Depends on tbrl_pkg and tbrl_core.
//
// Usage:
//   Input words arrive on the s_axis channel: tuser carries the mode (tick, request,
//   speed change, start, stop), tdata carries the amount and the signed burst argument.
//   Every input word yields exactly one result word on m_axis: a status code (ok,
//   rejected, retry) and the tokens still available after the word.
//   A word is accepted when tvalid and tready are both high at a rising clock edge.
//   A word is held in the input register, then its result is computed into the output
//   register, where the bucket state is updated in the same cycle.
//   Throughput is one word per cycle while the receiver does not stall; the next word
//   sees the state left by the one before it, as the state updates when its result loads.
//   When the receiver stalls, the result holds in the output register and one more
//   word is still taken into the input register; after that s_axis_tready drops.
//   cfg_wen/cfg_wdata load the speed at once; write it only while no word is in flight.
//   Reset (rst_n low, asynchronous) clears all counters, the speed and the pending
//   speed, puts the bucket in the stopped state and empties both registers.
module token_bucket_rate_limiter
    import tbrl_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration: initial speed
    input  logic                cfg_wen,
    input  logic [SPEED_W-1:0]  cfg_wdata,
    // Input words
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // [15:0] amount, [31:16] burst_arg
    input  logic [MODE_W-1:0]   s_axis_tuser,   // [2:0] mode
    // Result words
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata    // [1:0] status, [18:2] tokens_available
);

    // Input register; only the sign of the burst argument matters
    logic                in_valid_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [SPEED_W-1:0]  amount_reg;
    logic                burst_neg_reg;

    // Bucket state
    logic [COUNTER_BITS-1:0] consumed_reg;
    logic [COUNTER_BITS-1:0] refill_reg;
    logic [COUNTER_BITS-1:0] limit_reg;
    logic [SPEED_W-1:0]      speed_reg;
    logic [SPEED_W-1:0]      pending_reg;
    run_state_t              run_state_reg;

    logic [COUNTER_BITS-1:0] consumed_next;
    logic [COUNTER_BITS-1:0] refill_next;
    logic [COUNTER_BITS-1:0] limit_next;
    logic [SPEED_W-1:0]      speed_next;
    logic [SPEED_W-1:0]      pending_next;
    run_state_t              run_state_next;
    status_t                 status_next;
    logic [AVAIL_W-1:0]      avail_next;

    // Result register
    logic                out_valid_reg;
    status_t             status_reg;
    logic [AVAIL_W-1:0]  avail_reg;

    logic advance;
    logic in_take;

    // Move the held word into the result register when there is room for it
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    tbrl_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .mode             (mode_reg),
        .amount           (amount_reg),
        .burst_neg        (burst_neg_reg),
        .consumed         (consumed_reg),
        .refill           (refill_reg),
        .limit            (limit_reg),
        .speed            (speed_reg),
        .pending          (pending_reg),
        .run_state        (run_state_reg),
        .consumed_next    (consumed_next),
        .refill_next      (refill_next),
        .limit_next       (limit_next),
        .speed_next       (speed_next),
        .pending_next     (pending_next),
        .run_state_next   (run_state_next),
        .status           (status_next),
        .tokens_available (avail_next)
    );

    // Input register: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg      <= s_axis_tuser;
            amount_reg    <= s_axis_tdata[15:0];
            burst_neg_reg <= s_axis_tdata[31];
        end
    end

    // Bucket state: update as the result is loaded; config loads the speed directly
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            consumed_reg  <= '0;
            refill_reg    <= '0;
            limit_reg     <= '0;
            speed_reg     <= '0;
            pending_reg   <= '0;
            run_state_reg <= RS_STOPPED;
        end
        else if (cfg_wen)
        begin
            speed_reg <= cfg_wdata;
        end
        else if (advance)
        begin
            consumed_reg  <= consumed_next;
            refill_reg    <= refill_next;
            limit_reg     <= limit_next;
            speed_reg     <= speed_next;
            pending_reg   <= pending_next;
            run_state_reg <= run_state_next;
        end
    end

    // Result register: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Result register: payload, hold while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            avail_reg  <= avail_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, avail_reg, status_reg};

endmodule

/* src/tbrl_core.sv */
// Next-state and result logic for one word of the token bucket rate limiter.
// Purely combinational; uses tbrl_pkg types and constants.
module tbrl_core
    import tbrl_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  logic [MODE_W-1:0]       mode,
    input  logic [SPEED_W-1:0]      amount,
    input  logic                    burst_neg,
    input  logic [COUNTER_BITS-1:0] consumed,
    input  logic [COUNTER_BITS-1:0] refill,
    input  logic [COUNTER_BITS-1:0] limit,
    input  logic [SPEED_W-1:0]      speed,
    input  logic [SPEED_W-1:0]      pending,
    input  run_state_t              run_state,
    output logic [COUNTER_BITS-1:0] consumed_next,
    output logic [COUNTER_BITS-1:0] refill_next,
    output logic [COUNTER_BITS-1:0] limit_next,
    output logic [SPEED_W-1:0]      speed_next,
    output logic [SPEED_W-1:0]      pending_next,
    output run_state_t              run_state_next,
    output status_t                 status,
    output logic [AVAIL_W-1:0]      tokens_available
);

    localparam logic [COUNTER_BITS-1:0] AVAIL_LIM = COUNTER_BITS'(AVAIL_MAX);

    logic [COUNTER_BITS-1:0] tick_diff;
    logic [COUNTER_BITS-1:0] tick_diff_pos;
    logic [COUNTER_BITS-1:0] tick_speed_ext;
    logic [SPEED_W-1:0]      tick_speed;
    logic [SPEED_W-1:0]      carry;
    logic [COUNTER_BITS-1:0] token_diff;
    logic [COUNTER_BITS-1:0] amount_ext;
    logic [COUNTER_BITS-1:0] avail_diff;

    // Tick: apply a pending speed first, then carry leftover tokens
    assign tick_speed     = (run_state == RS_PENDING) ? pending : speed;
    assign tick_speed_ext = COUNTER_BITS'(tick_speed);
    assign tick_diff      = refill - consumed;
    assign tick_diff_pos  = tick_diff[COUNTER_BITS-1] ? '0 : tick_diff;
    assign carry          = (tick_diff_pos < tick_speed_ext) ? tick_diff_pos[SPEED_W-1:0]
                                                             : tick_speed;

    assign token_diff = limit - consumed;
    assign amount_ext = COUNTER_BITS'(amount);

    always_comb
    begin
        consumed_next  = consumed;
        refill_next    = refill;
        limit_next     = limit;
        speed_next     = speed;
        pending_next   = pending;
        run_state_next = run_state;
        status         = ST_OK;
        case (mode)
            MODE_TICK:
            begin
                if (run_state == RS_RUNNING || run_state == RS_PENDING)
                begin
                    speed_next     = tick_speed;
                    run_state_next = RS_RUNNING;
                    refill_next    = consumed + tick_speed_ext;
                    limit_next     = consumed + tick_speed_ext + COUNTER_BITS'(carry);
                end
            end
            MODE_REQUEST:
            begin
                if (speed != '0 && amount > speed)
                    status = ST_REJECT;
                else if (token_diff[COUNTER_BITS-1] || token_diff < amount_ext)
                    status = ST_RETRY;
                else
                    consumed_next = consumed + amount_ext;
            end
            MODE_SPEED:
            begin
                if (amount == '0 || burst_neg || run_state == RS_PENDING)
                    status = ST_REJECT;
                else if (run_state == RS_STOPPED)
                    speed_next = amount;
                else
                begin
                    pending_next   = amount;
                    run_state_next = RS_PENDING;
                end
            end
            MODE_START:
            begin
                refill_next    = COUNTER_BITS'(speed);
                limit_next     = COUNTER_BITS'(speed);
                run_state_next = RS_RUNNING;
            end
            MODE_STOP:
            begin
                run_state_next = RS_STOPPED;
            end
            default:
            begin
                status = ST_REJECT;
            end
        endcase
    end

    // Tokens left after this word, clamped to the output range
    assign avail_diff = limit_next - consumed_next;

    always_comb
    begin
        if (avail_diff[COUNTER_BITS-1])
            tokens_available = '0;
        else if (avail_diff > AVAIL_LIM)
            tokens_available = AVAIL_MAX;
        else
            tokens_available = avail_diff[AVAIL_W-1:0];
    end

endmodule
